/* rtl/cle_pkg.sv */
// ============================================================================
// cle_pkg
// Shared constants, codes and controller/datapath interface types for the
// canonical line editor.
// ============================================================================
package cle_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int MAX_READ   = 32;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int SIZE_W = 6;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int ACT_W  = 4;
    localparam int SEL_W  = 3;

    localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'd8;
    localparam logic [BYTE_W-1:0] KEY_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] KEY_SPACE     = 8'd32;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_EMPTY   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_WAIT    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_READ    = 4'd3;
    localparam logic [ACT_W-1:0] ACT_REFUSE  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_BS      = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ECHO    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_NL      = 4'd7;
    localparam logic [ACT_W-1:0] ACT_NL_READ = 4'd8;

    localparam logic [SEL_W-1:0] SEL_ECHO    = 3'd0;
    localparam logic [SEL_W-1:0] SEL_ECHO_NL = 3'd1;
    localparam logic [SEL_W-1:0] SEL_EMPTY   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_REFUSE  = 3'd3;
    localparam logic [SEL_W-1:0] SEL_BS      = 3'd4;
    localparam logic [SEL_W-1:0] SEL_SPACE   = 3'd5;
    localparam logic [SEL_W-1:0] SEL_BS_LAST = 3'd6;
    localparam logic [SEL_W-1:0] SEL_DATA    = 3'd7;

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic [SEL_W-1:0] sel;
    } cle_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             slot_free;
        logic             dlv_last;
    } cle_status_t;

endpackage

/* rtl/cle_ram.sv */
// ============================================================================
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/cle_datapath.sv */
// ============================================================================
// cle_datapath
// Line state, line RAM, read delivery counters and the output register.
// ============================================================================
module cle_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op,
    input  logic [15:0]           in_data,
    input  cle_pkg::cle_cmd_t     cmd,
    output cle_pkg::cle_status_t  stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_kind,
    output logic [15:0]           out_data,
    output logic                  out_last
);

    import cle_pkg::*;

    logic [BYTE_W-1:0] key;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] size_sat;
    logic [ACT_W-1:0]  act;
    logic              room;
    logic              line_end;
    logic [LEN_W-1:0]  pos_inc;
    logic [SIZE_W-1:0] cnt_inc;
    logic              dlv_last;
    logic              store_en;
    logic [BYTE_W-1:0] rd_byte;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              ready_reg, ready_next;
    logic              waiting_reg, waiting_next;
    logic [SIZE_W-1:0] wsize_reg, wsize_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] limit_reg, limit_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] key_reg, key_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [SIZE_W-1:0] count_reg, count_next;
    logic              last_reg, last_next;

    assign key      = in_data[BYTE_W-1:0];
    assign size     = in_data[BYTE_W+SIZE_W-1:BYTE_W];
    assign size_sat = (size > SIZE_W'(MAX_READ)) ? SIZE_W'(MAX_READ) : size;
    assign room     = len_reg < LEN_W'(LINE_DEPTH);
    assign pos_inc  = pos_reg + LEN_W'(1);
    assign cnt_inc  = cnt_reg + SIZE_W'(1);
    assign line_end = pos_inc >= len_reg;
    assign dlv_last = line_end || (cnt_inc >= limit_reg);

    always_comb
    begin
        if (op == OP_READ)
        begin
            if (size == '0)
                act = ACT_EMPTY;
            else if (ready_reg)
                act = ACT_READ;
            else
                act = ACT_WAIT;
        end
        else if (ready_reg)
            act = ACT_REFUSE;
        else if (key == KEY_BACKSPACE)
            act = (len_reg == '0) ? ACT_NONE : ACT_BS;
        else if (key == KEY_NEWLINE)
            act = waiting_reg ? ACT_NL_READ : ACT_NL;
        else
            act = ACT_ECHO;
    end

    assign stat.act       = act;
    assign stat.slot_free = !valid_reg || out_ready;
    assign stat.dlv_last  = dlv_last;

    assign store_en = cmd.accept && room &&
                      (act == ACT_ECHO || act == ACT_NL || act == ACT_NL_READ);

    always_comb
    begin
        len_next     = len_reg;
        pos_next     = pos_reg;
        ready_next   = ready_reg;
        waiting_next = waiting_reg;
        wsize_next   = wsize_reg;
        cnt_next     = cnt_reg;
        limit_next   = limit_reg;
        key_next     = key_reg;

        if (cmd.accept)
        begin
            key_next = key;
            unique case (act) inside
                ACT_WAIT:
                begin
                    waiting_next = 1'b1;
                    wsize_next   = size_sat;
                end
                ACT_READ:
                begin
                    limit_next = size_sat;
                    cnt_next   = '0;
                end
                ACT_BS:
                begin
                    len_next = len_reg - LEN_W'(1);
                end
                ACT_ECHO:
                begin
                    if (room)
                        len_next = len_reg + LEN_W'(1);
                end
                ACT_NL:
                begin
                    if (room)
                        len_next = len_reg + LEN_W'(1);
                    ready_next = 1'b1;
                    pos_next   = '0;
                end
                ACT_NL_READ:
                begin
                    if (room)
                        len_next = len_reg + LEN_W'(1);
                    ready_next   = 1'b1;
                    pos_next     = '0;
                    waiting_next = 1'b0;
                    limit_next   = wsize_reg;
                    cnt_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.emit && cmd.sel == SEL_DATA)
        begin
            cnt_next = cnt_inc;
            if (line_end)
            begin
                pos_next   = '0;
                len_next   = '0;
                ready_next = 1'b0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        count_next = count_reg;
        last_next  = last_reg;

        if (cmd.emit)
        begin
            valid_next = 1'b1;
            count_next = '0;
            last_next  = 1'b0;
            kind_next  = KIND_ECHO;
            byte_next  = key_reg;
            case (cmd.sel)
                SEL_ECHO:
                begin
                    last_next = 1'b1;
                end
                SEL_ECHO_NL:
                begin
                    last_next = 1'b0;
                end
                SEL_EMPTY:
                begin
                    kind_next = KIND_EMPTY;
                    byte_next = '0;
                    last_next = 1'b1;
                end
                SEL_REFUSE:
                begin
                    kind_next = KIND_REFUSED;
                    last_next = 1'b1;
                end
                SEL_BS:
                begin
                    byte_next = KEY_BACKSPACE;
                end
                SEL_SPACE:
                begin
                    byte_next = KEY_SPACE;
                end
                SEL_BS_LAST:
                begin
                    byte_next = KEY_BACKSPACE;
                    last_next = 1'b1;
                end
                default:
                begin
                    kind_next  = KIND_DATA;
                    byte_next  = rd_byte;
                    count_next = cnt_inc;
                    last_next  = dlv_last;
                end
            endcase
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            pos_reg     <= '0;
            ready_reg   <= 1'b0;
            waiting_reg <= 1'b0;
            wsize_reg   <= '0;
            cnt_reg     <= '0;
            limit_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            ready_reg   <= ready_next;
            waiting_reg <= waiting_next;
            wsize_reg   <= wsize_next;
            cnt_reg     <= cnt_next;
            limit_reg   <= limit_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        count_reg <= count_next;
        last_reg  <= last_next;
    end

    // read port follows the next read position, so its registered data is ready when that position becomes current
    cle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (key),
        .rd_addr (pos_next[ADDR_W-1:0]),
        .rd_data (rd_byte)
    );

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = {2'b00, count_reg, byte_reg};
    assign out_last  = last_reg;

endmodule

/* rtl/cle_ctrl.sv */
// ============================================================================
// cle_ctrl
// Sequencer: accepts one request at a time and steps through its results.
// ============================================================================
module cle_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cle_pkg::cle_status_t  stat,
    output cle_pkg::cle_cmd_t     cmd
);

    import cle_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_ECHO    = 4'd1;
    localparam logic [3:0] ST_ECHO_NL = 4'd2;
    localparam logic [3:0] ST_EMPTY   = 4'd3;
    localparam logic [3:0] ST_REFUSE  = 4'd4;
    localparam logic [3:0] ST_BS1     = 4'd5;
    localparam logic [3:0] ST_BS2     = 4'd6;
    localparam logic [3:0] ST_BS3     = 4'd7;
    localparam logic [3:0] ST_DLV     = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    unique case (stat.act) inside
                        ACT_EMPTY:           state_next = ST_EMPTY;
                        ACT_READ:            state_next = ST_DLV;
                        ACT_REFUSE:          state_next = ST_REFUSE;
                        ACT_BS:              state_next = ST_BS1;
                        ACT_ECHO, ACT_NL:    state_next = ST_ECHO;
                        ACT_NL_READ:         state_next = ST_ECHO_NL;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ECHO:
            begin
                cmd.sel  = SEL_ECHO;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_IDLE;
            end
            ST_ECHO_NL:
            begin
                cmd.sel  = SEL_ECHO_NL;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_DLV;
            end
            ST_EMPTY:
            begin
                cmd.sel  = SEL_EMPTY;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_IDLE;
            end
            ST_REFUSE:
            begin
                cmd.sel  = SEL_REFUSE;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_IDLE;
            end
            ST_BS1:
            begin
                cmd.sel  = SEL_BS;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_BS2;
            end
            ST_BS2:
            begin
                cmd.sel  = SEL_SPACE;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_BS3;
            end
            ST_BS3:
            begin
                cmd.sel  = SEL_BS_LAST;
                cmd.emit = stat.slot_free;
                if (stat.slot_free)
                    state_next = ST_IDLE;
            end
            ST_DLV:
            begin
                cmd.sel  = SEL_DATA;
                cmd.emit = stat.slot_free;
                if (stat.slot_free && stat.dlv_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/canonical_line_editor.sv */
// ============================================================================
// canonical_line_editor
// Cooked-mode line editor: echoes keys, edits and completes a line in a
// line RAM, and serves read requests from the completed line.
// ============================================================================
//
// channel  dir  payload
// s_*      in   tuser: operation; tdata: key_char, read_size
// m_*      out  tuser: kind; tdata: data_byte, byte_count; tlast: last
//
// A request is taken while s_tready is high; its results follow in order while m_tready
// is high: a single result, backspace/space/backspace for a backspace, up to n bytes
// for a read of n, an echo then up to n bytes for a newline that serves a waiting read.
// Unstalled, read bytes stream at one per cycle from the registered line RAM port.
// s_tready is high only between requests; a stalled output holds the sequencer.
// Reset clears the line state at once; line RAM contents stay undefined.
//
module canonical_line_editor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] key_char, [13:8] read_size, [15:14] zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [13:8] byte_count, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    import cle_pkg::*;

    cle_cmd_t    cmd;
    cle_status_t stat;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cle_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_DATA) |-> m_tdata[13:8] != 6'd0)
        else $error("read data result without byte count");

    a_other_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_DATA) |-> m_tdata[13:8] == 6'd0)
        else $error("non-data result with byte count");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_EMPTY || m_tuser == KIND_REFUSED)) |-> m_tlast)
        else $error("single result without last");

    a_no_emit_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.emit)
        else $error("accept and emit in the same cycle");
`endif

endmodule
